// File: rtl/core/rdcd_pkg.sv
// ----------------------------------------------------------------------------
// rdcd_pkg
// types and constants shared by the remote drive command decoder
// ----------------------------------------------------------------------------
package rdcd_pkg;

   // one received character with its end-of-message mark
   typedef struct packed {
      logic [7:0] rx_char;
      logic       end_of_message;
   } req_type;

   // one decoded message result
   typedef struct packed {
      logic [3:0]  drive_mode;
      logic [15:0] drive_speed;
      logic [7:0]  open_angle;
      logic [7:0]  press_angle;
      logic        led_toggle;
      logic [15:0] command_value;
   } rsp_type;

   // parser view of the message after the current character
   typedef struct packed {
      logic [7:0]  cmd;
      logic [15:0] value;
   } parse_result_type;

   typedef enum logic [1:0] {
      PH_COMMAND,
      PH_PREFIX,
      PH_DIGITS,
      PH_STOPPED
   } phase_type;

   // command characters
   localparam logic [7:0] CMD_FWD        = 8'h46; // F
   localparam logic [7:0] CMD_BACK       = 8'h42; // B
   localparam logic [7:0] CMD_LEFT       = 8'h4C; // L
   localparam logic [7:0] CMD_RIGHT      = 8'h52; // R
   localparam logic [7:0] CMD_HALT       = 8'h48; // H
   localparam logic [7:0] CMD_OPEN       = 8'h4F; // O
   localparam logic [7:0] CMD_CLOSE      = 8'h43; // C
   localparam logic [7:0] CMD_PRESS      = 8'h50; // P
   localparam logic [7:0] CMD_SPIN_LEFT  = 8'h58; // X
   localparam logic [7:0] CMD_SPIN_RIGHT = 8'h59; // Y

   // other characters
   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_CR    = 8'h0D;

   // drive modes
   localparam logic [3:0] MODE_STOP       = 4'd0;
   localparam logic [3:0] MODE_FWD        = 4'd1;
   localparam logic [3:0] MODE_BACK       = 4'd2;
   localparam logic [3:0] MODE_LEFT       = 4'd3;
   localparam logic [3:0] MODE_RIGHT      = 4'd4;
   localparam logic [3:0] MODE_OPEN       = 4'd5;
   localparam logic [3:0] MODE_CLOSE      = 4'd6;
   localparam logic [3:0] MODE_PRESS      = 4'd7;
   localparam logic [3:0] MODE_RELEASE    = 4'd8;
   localparam logic [3:0] MODE_SPIN_LEFT  = 4'd9;
   localparam logic [3:0] MODE_SPIN_RIGHT = 4'd10;

   localparam logic [7:0]  ANGLE_LIMIT_RESET = 8'd88;
   localparam logic [15:0] VALUE_MAX         = 16'hFFFF;

endpackage

// File: rtl/core/remote_drive_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// remote_drive_command_decoder_unit
// text command decoder for a remote vehicle, one character per transfer
// ----------------------------------------------------------------------------
//
//   port group  | dir | payload              | transfer when
//   ------------+-----+----------------------+---------------------------
//   req_        | in  | rx_char, end mark    | req_valid && req_ready
//   rsp_        | out | mode, speed, angles  | rsp_valid && rsp_ready
//   csr_        | in  | servo angle limit    | csr_valid (always ready)
//
// one character transfer per cycle while no stalled result holds back an end-marked
// character, no gap needed between transfers; a result passes the input register,
// then the result register, after the transfer of its last character
// a stalled result holds back only a character carrying the end mark; it
// waits in the input register, with req_ready low, until the result frees up
// synchronous active-high reset: mode stop, speed and angles zero, limit 88
//
module remote_drive_command_decoder_unit #(
   parameter int MAX_MESSAGE_LEN = 20
) (
   input  logic              clock,
   input  logic              reset,
   // character input
   input  logic              req_valid,
   output logic              req_ready,
   input  rdcd_pkg::req_type req_data,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rdcd_pkg::rsp_type rsp_data,
   // angle limit register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import rdcd_pkg::*;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // config
   logic [7:0] limit_ff;

   logic             char_fire;
   logic             msg_fire;
   logic             req_fire;
   parse_result_type parse_result;
   rsp_type          result;

   // the buffered character moves on unless it would produce a result
   // into a full, stalled result register
   assign char_fire = in_valid_ff &&
                      (!in_data_ff.end_of_message || !rsp_valid_ff || rsp_ready);
   assign msg_fire  = char_fire && in_data_ff.end_of_message;
   assign req_ready = !in_valid_ff || char_fire;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !char_fire);
   assign rsp_valid_in = msg_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   rdcd_parser #(
      .MAX_MESSAGE_LEN(MAX_MESSAGE_LEN)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .char_fire   (char_fire),
      .char_data   (in_data_ff),
      .parse_result(parse_result)
   );

   rdcd_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .msg_fire    (msg_fire),
      .parse_result(parse_result),
      .angle_limit (limit_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (msg_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // angle limit register, writes always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ANGLE_LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

`ifndef SYNTHESIS
   // a new result only comes from a message end leaving the input register
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(msg_fire))
      else $error("result raised without a message end");

   // the led only toggles together with the open mode
   a_led_open : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.led_toggle |-> rsp_data_ff.drive_mode == MODE_OPEN)
      else $error("led toggle without open mode");

   // mode stays within the defined codes
   a_mode_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.drive_mode <= MODE_SPIN_RIGHT)
      else $error("drive mode out of range");

   // an end-marked character never passes while the result register is stuck
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !msg_fire)
      else $error("result overwritten while stalled");
`endif

endmodule

// File: rtl/core/rdcd_parser.sv
// ----------------------------------------------------------------------------
// rdcd_parser
// per-character command and decimal number parser; a negative or overflowing number reads as zero
// ----------------------------------------------------------------------------
module rdcd_parser #(
   parameter int MAX_MESSAGE_LEN = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      char_fire,
   input  rdcd_pkg::req_type         char_data,
   output rdcd_pkg::parse_result_type parse_result
);
   import rdcd_pkg::*;

   localparam int CW = $clog2(MAX_MESSAGE_LEN + 1);

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic        neg_ff, neg_in;
   logic [CW-1:0] count_ff, count_in;

   logic [7:0]  c;
   logic        take;
   logic        digit;
   logic        space;
   logic        add;
   logic [19:0] acc_sum;

   assign c     = char_data.rx_char;
   assign take  = (count_ff < CW'(MAX_MESSAGE_LEN));
   assign digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
   assign space = (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
   assign acc_sum = ({4'd0, acc_ff} * 20'd10) + {16'd0, c[3:0]};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_COMMAND: phase_in = (c == CHR_NUL) ? PH_STOPPED : PH_PREFIX;
            PH_PREFIX: begin
               if (digit || c == CHR_PLUS || c == CHR_MINUS) begin
                  phase_in = PH_DIGITS;
               end else if (!space) begin
                  phase_in = PH_STOPPED;
               end
            end
            PH_DIGITS:  phase_in = digit ? PH_DIGITS : PH_STOPPED;
            default:    phase_in = phase_ff;
         endcase
      end
   end

   // datapath
   always_comb begin
      cmd_in   = cmd_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      add      = 1'b0;
      if (take) begin
         count_in = count_ff + CW'(1);
         unique case (phase_ff)
            PH_COMMAND: cmd_in = c;
            PH_PREFIX: begin
               if (digit) begin
                  add = 1'b1;
               end else if (c == CHR_PLUS || c == CHR_MINUS) begin
                  neg_in = (c == CHR_MINUS);
               end
            end
            PH_DIGITS:  add = digit;
            default:    add = 1'b0;
         endcase
      end
      if (add && !ovf_ff) begin
         if (acc_sum > {4'd0, VALUE_MAX}) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = acc_sum[15:0];
         end
      end
   end

   assign parse_result.cmd   = cmd_in;
   assign parse_result.value = (ovf_in || neg_in) ? 16'd0 : acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COMMAND;
         cmd_ff   <= CHR_NUL;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         count_ff <= '0;
      end else if (char_fire) begin
         if (char_data.end_of_message) begin
            // message done, start over
            phase_ff <= PH_COMMAND;
            cmd_ff   <= CHR_NUL;
            acc_ff   <= '0;
            ovf_ff   <= 1'b0;
            neg_ff   <= 1'b0;
            count_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            neg_ff   <= neg_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

// File: rtl/core/rdcd_exec.sv
// ----------------------------------------------------------------------------
// rdcd_exec
// applies a completed command to the drive mode, speed and servo angles
// ----------------------------------------------------------------------------
module rdcd_exec (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       msg_fire,
   input  rdcd_pkg::parse_result_type parse_result,
   input  logic [7:0]                 angle_limit,
   output rdcd_pkg::rsp_type          result
);
   import rdcd_pkg::*;

   logic [3:0]  mode_ff, mode_in;
   logic [15:0] speed_ff, speed_in;
   logic [7:0]  open_ff, open_in;
   logic [7:0]  press_ff, press_in;
   logic        led;
   logic [7:0]  clamped;

   assign clamped = (parse_result.value > {8'd0, angle_limit}) ? angle_limit
                                                               : parse_result.value[7:0];

   always_comb begin
      mode_in  = mode_ff;
      speed_in = speed_ff;
      open_in  = open_ff;
      press_in = press_ff;
      led      = 1'b0;
      unique case (parse_result.cmd)
         CMD_FWD: begin
            mode_in  = MODE_FWD;
            speed_in = parse_result.value;
         end
         CMD_BACK: begin
            mode_in  = MODE_BACK;
            speed_in = parse_result.value;
         end
         CMD_LEFT:  mode_in = MODE_LEFT;
         CMD_RIGHT: mode_in = MODE_RIGHT;
         CMD_HALT:  mode_in = MODE_STOP;
         CMD_OPEN: begin
            led     = 1'b1;
            mode_in = MODE_OPEN;
            open_in = clamped;
         end
         CMD_CLOSE: mode_in = MODE_CLOSE;
         CMD_PRESS: begin
            // alternate between press and release
            if (mode_ff == MODE_PRESS) begin
               mode_in = MODE_RELEASE;
            end else begin
               mode_in  = MODE_PRESS;
               press_in = clamped;
            end
         end
         CMD_SPIN_LEFT:  mode_in = MODE_SPIN_LEFT;
         CMD_SPIN_RIGHT: mode_in = MODE_SPIN_RIGHT;
         default:        mode_in = mode_ff;
      endcase
   end

   assign result.drive_mode    = mode_in;
   assign result.drive_speed   = speed_in;
   assign result.open_angle    = open_in;
   assign result.press_angle   = press_in;
   assign result.led_toggle    = led;
   assign result.command_value = parse_result.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STOP;
         speed_ff <= '0;
         open_ff  <= '0;
         press_ff <= '0;
      end else if (msg_fire) begin
         mode_ff  <= mode_in;
         speed_ff <= speed_in;
         open_ff  <= open_in;
         press_ff <= press_in;
      end
   end

endmodule

// File: sim/rdcd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdcd_checker
// watches the decoder's channels, predicts each message result and compares
// every result transfer field by field with the oldest pending prediction
// ----------------------------------------------------------------------------
module rdcd_checker #(
   parameter int MAX_MESSAGE_LEN = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rdcd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rdcd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [7:0]        csr_data,
   output int                fail_count,
   output int                outstanding
);

   import rdcd_pkg::*;

   // predictor state
   logic [7:0]  angle_limit;
   phase_type   scan_phase;
   logic [7:0]  cmd_char;
   logic [16:0] number_acc;
   logic        number_ovf;
   logic        number_neg;
   int          msg_len;
   logic [3:0]  mode_q;
   logic [15:0] speed_q;
   logic [7:0]  open_q;
   logic [7:0]  press_q;

   rsp_type     decoded_q [$];
   int          mismatches;

   task automatic clear_scan();
      scan_phase = PH_COMMAND;
      cmd_char   = CHR_NUL;
      number_acc = '0;
      number_ovf = 1'b0;
      number_neg = 1'b0;
      msg_len    = 0;
   endtask

   // decimal accumulate, saturating once past the 16-bit range
   task automatic add_digit(input logic [7:0] c);
      logic [20:0] grown;
      logic [7:0]  d;
      if (!number_ovf) begin
         d     = c - CHR_ZERO;
         grown = {4'd0, number_acc} * 21'd10 + {13'd0, d};
         if (grown > {5'd0, VALUE_MAX}) begin
            number_ovf = 1'b1;
            number_acc = 17'h10000;
         end else begin
            number_acc = grown[16:0];
         end
      end
   endtask

   function automatic logic [7:0] clamp_angle(input logic [15:0] v);
      return (v > {8'd0, angle_limit}) ? angle_limit : v[7:0];
   endfunction

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v !== got_v) begin
         mismatches++;
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type     want;
      rsp_type     made;
      logic [7:0]  ch;
      logic        is_digit;
      logic [15:0] value;
      logic        led;
      if (reset) begin
         angle_limit = ANGLE_LIMIT_RESET;
         mode_q      = MODE_STOP;
         speed_q     = '0;
         open_q      = '0;
         press_q     = '0;
         clear_scan();
         decoded_q.delete();
         mismatches  = 0;
      end else begin
         if (csr_valid && csr_ready)
            angle_limit = csr_data;

         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               mismatches++;
               $error("rsp_data: expected no transfer, actual %h", rsp_data);
            end else begin
               want = decoded_q.pop_front();
               check_field("drive_mode", 32'(want.drive_mode),
                           32'(rsp_data.drive_mode));
               check_field("drive_speed", 32'(want.drive_speed),
                           32'(rsp_data.drive_speed));
               check_field("open_angle", 32'(want.open_angle),
                           32'(rsp_data.open_angle));
               check_field("press_angle", 32'(want.press_angle),
                           32'(rsp_data.press_angle));
               check_field("led_toggle", 32'(want.led_toggle),
                           32'(rsp_data.led_toggle));
               check_field("command_value", 32'(want.command_value),
                           32'(rsp_data.command_value));
            end
         end

         if (req_valid && req_ready) begin
            // characters past the length cap are dropped
            if (msg_len < MAX_MESSAGE_LEN) begin
               msg_len++;
               ch       = req_data.rx_char;
               is_digit = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
               case (scan_phase)
                  PH_COMMAND: begin
                     cmd_char = ch;
                     if (ch == CHR_NUL)
                        scan_phase = PH_STOPPED;
                     else
                        scan_phase = PH_PREFIX;
                  end
                  PH_PREFIX: begin
                     if (is_digit) begin
                        add_digit(ch);
                        scan_phase = PH_DIGITS;
                     end else if (ch == CHR_PLUS || ch == CHR_MINUS) begin
                        number_neg = (ch == CHR_MINUS);
                        scan_phase = PH_DIGITS;
                     end else if (!(ch == CHR_SPACE || (ch >= CHR_TAB && ch <= CHR_CR))) begin
                        scan_phase = PH_STOPPED;
                     end
                  end
                  PH_DIGITS: begin
                     if (is_digit)
                        add_digit(ch);
                     else
                        scan_phase = PH_STOPPED;
                  end
                  default: ;
               endcase
            end

            if (req_data.end_of_message) begin
               value = (number_ovf || number_neg) ? 16'd0 : number_acc[15:0];
               led   = 1'b0;
               case (cmd_char)
                  CMD_FWD: begin
                     mode_q  = MODE_FWD;
                     speed_q = value;
                  end
                  CMD_BACK: begin
                     mode_q  = MODE_BACK;
                     speed_q = value;
                  end
                  CMD_LEFT:       mode_q = MODE_LEFT;
                  CMD_RIGHT:      mode_q = MODE_RIGHT;
                  CMD_HALT:       mode_q = MODE_STOP;
                  CMD_OPEN: begin
                     led    = 1'b1;
                     mode_q = MODE_OPEN;
                     open_q = clamp_angle(value);
                  end
                  CMD_CLOSE:      mode_q = MODE_CLOSE;
                  CMD_PRESS: begin
                     if (mode_q == MODE_PRESS) begin
                        mode_q = MODE_RELEASE;
                     end else begin
                        mode_q  = MODE_PRESS;
                        press_q = clamp_angle(value);
                     end
                  end
                  CMD_SPIN_LEFT:  mode_q = MODE_SPIN_LEFT;
                  CMD_SPIN_RIGHT: mode_q = MODE_SPIN_RIGHT;
                  default: ;
               endcase
               made.drive_mode    = mode_q;
               made.drive_speed   = speed_q;
               made.open_angle    = open_q;
               made.press_angle   = press_q;
               made.led_toggle    = led;
               made.command_value = value;
               decoded_q.push_back(made);
               clear_scan();
            end
         end
      end
      fail_count  <= mismatches;
      outstanding <= decoded_q.size();
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives text messages into the remote drive command decoder, one character
// per transfer, under several angle limits and flow-control patterns; the
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;

   import rdcd_pkg::*;

   localparam int MSG_LEN        = 20;
   localparam int DRAIN_CYCLES   = 8;       // extra wait once no result is outstanding
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_CHARS    = 106;     // about 850 random characters overall
   localparam int RANDOM_PHASES  = 8;

   // blanks not named in the package
   localparam logic [7:0] CHR_LF = 8'h0A;
   localparam logic [7:0] CHR_VT = 8'h0B;
   localparam logic [7:0] CHR_FF = 8'h0C;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   req_type    req_data    = '0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid   = 1'b0;
   logic [7:0] csr_data    = '0;
   logic       csr_ready;

   int         fail_count;
   int         outstanding;

   // idle odds in percent, changed only between phases
   int         send_idle_pct  = 0;
   int         stall_idle_pct = 0;

   logic [7:0] msg_q [$];
   int         chars_sent     = 0;
   int         msgs_sent      = 0;
   int         limits_written = 0;
   int         cycle_count    = 0;

   remote_drive_command_decoder_unit #(
      .MAX_MESSAGE_LEN(MSG_LEN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   rdcd_checker #(
      .MAX_MESSAGE_LEN(MSG_LEN)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_idle_pct);
   end

   // cycle counter guarding against a hung handshake
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         msg_q.push_back(s[i]);
   endtask

   // send the queued message; the end mark rides on its last character
   task automatic send_message();
      int k;
      for (k = 0; k < msg_q.size(); k++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= '{rx_char: msg_q[k], end_of_message: (k == msg_q.size() - 1)};
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
         chars_sent++;
      end
      msgs_sent++;
      msg_q.delete();
   endtask

   task automatic say(input string s);
      push_text(s);
      send_message();
   endtask

   // drop valid, wait for every pending result, then let the pipe go quiet
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      limits_written++;
   endtask

   // known commands, press weighted up so press/release alternation shows up
   function automatic logic [7:0] pick_command();
      case ($urandom_range(11))
         0:       return CMD_FWD;
         1:       return CMD_BACK;
         2:       return CMD_LEFT;
         3:       return CMD_RIGHT;
         4:       return CMD_HALT;
         5:       return CMD_OPEN;
         6:       return CMD_CLOSE;
         7:       return CMD_SPIN_LEFT;
         8:       return CMD_SPIN_RIGHT;
         default: return CMD_PRESS;
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(5))
         0:       return CHR_TAB;
         1:       return CHR_LF;
         2:       return CHR_VT;
         3:       return CHR_FF;
         4:       return CHR_CR;
         default: return CHR_SPACE;
      endcase
   endfunction

   // mostly well-formed commands with random content, some overlong text
   // and some raw noise
   task automatic make_random_message();
      int kind;
      int pick;
      int n;
      kind = $urandom_range(99);
      if (kind < 72) begin
         msg_q.push_back(pick_command());
         n = $urandom_range(2);
         repeat (n) msg_q.push_back(pick_blank());
         pick = $urandom_range(99);
         if (pick < 25)
            msg_q.push_back(CHR_PLUS);
         else if (pick < 40)
            msg_q.push_back(CHR_MINUS);
         pick = $urandom_range(99);
         if (pick < 8) begin
            push_text("65535");
         end else if (pick < 14) begin
            push_text("65536");
         end else begin
            n = (pick < 80) ? $urandom_range(3) : $urandom_range(6, 4);
            repeat (n) msg_q.push_back(8'(CHR_ZERO + $urandom_range(9)));
         end
         // trailing junk, or a NUL with text behind it
         pick = $urandom_range(99);
         if (pick < 15) begin
            msg_q.push_back(8'($urandom_range(255)));
         end else if (pick < 25) begin
            msg_q.push_back(CHR_NUL);
            msg_q.push_back(8'(CHR_ZERO + $urandom_range(9)));
         end
      end else if (kind < 86) begin
         // long blank run so the length cap can cut into the digits
         msg_q.push_back(pick_command());
         n = $urandom_range(19, 10);
         repeat (n) msg_q.push_back(pick_blank());
         n = $urandom_range(8, 3);
         repeat (n) msg_q.push_back(8'(CHR_ZERO + $urandom_range(9)));
      end else begin
         n = $urandom_range(8, 1);
         repeat (n) msg_q.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin : stimulus
      int fixed_limits [4];
      int ph;
      int phase_start;
      fixed_limits = '{180, 0, 127, 1};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset limit, no idling
      say("F65535");                 // top of the speed range
      say("B65536");                 // one past the range reads as zero
      say("O200");                   // open angle clamps to the limit
      say("P-7");                    // negative value reads as zero
      say("P");                      // second press releases, missing number
      say("P+");                     // sign with no digit after it
      say("L");
      say("R");
      say("H");
      say("C");
      say("X");
      say("Y");
      say("Q12");                    // unknown command leaves state alone
      msg_q.push_back(CHR_NUL);      // NUL as the command character
      push_text("F9");
      send_message();
      say("O\t 45");                 // leading whitespace before the number
      push_text("F12");              // text after NUL is ignored
      msg_q.push_back(CHR_NUL);
      push_text("3");
      send_message();

      // random phases, each under its own limit and flow-control pattern
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         write_limit(8'((ph < 4) ? fixed_limits[ph] : $urandom_range(180)));
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               stall_idle_pct = 0;
            end
            1: begin
               send_idle_pct  = 47;
               stall_idle_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               stall_idle_pct = 47;
            end
            default: begin
               send_idle_pct  = 19;
               stall_idle_pct = 19;
            end
         endcase
         phase_start = chars_sent;
         while (chars_sent - phase_start < PHASE_CHARS) begin
            make_random_message();
            send_message();
         end
      end

      settle();
      $display("covered %0d characters in %0d messages under %0d angle limits",
               chars_sent, msgs_sent, limits_written + 1);
      $display("flow control: free running, sender gaps, receiver stalls, both");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/rdcd_pkg.sv
rtl/core/rdcd_parser.sv
rtl/core/rdcd_exec.sv
rtl/core/remote_drive_command_decoder_unit.sv
sim/rdcd_checker.sv
sim/tb_top.sv
